### hw/rtl/bdmp_pkg.sv
// Shared types and constants for the bit-density mip pyramid.
`default_nettype none

package bdmp_pkg;

	// Fixed field widths of the request and result items
	localparam int SAMPLE_W = 32;
	localparam int SEL_W    = 5;
	localparam int LEVEL_W  = 3;
	localparam int INDEX_W  = 33;
	localparam int VALUE_W  = 8;

	// Channels that carry data; a select at or above this reads as zero
	localparam int CHANNELS = 32;

	// Defaults for the top-level parameters
	localparam int DEF_LEVELS     = 4;
	localparam int DEF_BLOCK_LOG2 = 7;
	localparam int DEF_COUNT_BITS = 40;

	// One request: a logic sample and its end-of-trace mark
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_bits;
		logic                end_of_trace;
	} in_t;

	// One result: a finished block at one pyramid level
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [INDEX_W-1:0] block_index;
		logic [VALUE_W-1:0] block_value;
		logic               last_result;
	} out_t;

endpackage

`default_nettype wire

### hw/rtl/bdmp_engine.sv
// Input stage and pyramid update: counts the chosen bit and builds the result set.
`default_nettype none

module bdmp_engine
	import bdmp_pkg::*;
#(
	parameter int LEVELS     = DEF_LEVELS,
	parameter int BLOCK_LOG2 = DEF_BLOCK_LOG2,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [SEL_W-1:0] cfg_wdata,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire in_t              in_req,
	output logic                  push_valid,
	input  wire logic             push_ready,
	output out_t                  push_res [LEVELS]
);

	localparam int SUM_W = 2 * BLOCK_LOG2 + 1;
	localparam int VAL_W = BLOCK_LOG2 + 1;
	localparam logic [SUM_W-1:0] ROUND_UP = SUM_W'((1 << BLOCK_LOG2) - 1);

	logic [SEL_W-1:0]      chan_sel_q;
	logic                  valid_s1;
	logic [SAMPLE_W-1:0]   sample_s1;
	logic                  eot_s1;
	logic [COUNT_BITS-1:0] count_q;
	logic [SUM_W-1:0]      sum_q  [LEVELS];
	logic [SUM_W-1:0]      sum_nx [LEVELS];
	logic [COUNT_BITS-1:0] count_nx;
	logic [LEVELS:0]       emit;
	logic                  consume;

	// Channel select register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_sel_q <= '0;
		end else if (cfg_we) begin
			chan_sel_q <= cfg_wdata;
		end
	end

	// The stage empties when its item makes no result or the result set is taken
	assign consume    = valid_s1 && (!emit[0] || push_ready);
	assign in_ready   = !valid_s1 || consume;
	assign push_valid = valid_s1 && emit[0];

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= in_req.sample_bits;
			eot_s1    <= in_req.end_of_trace;
		end
	end

	// Level cascade: each finished block feeds its value to the level above
	always_comb begin
		logic                          sel_bit;
		logic [SUM_W-1:0]              addend;
		logic [SUM_W-1:0]              sum_add;
		logic [VAL_W-1:0]              val;
		logic [COUNT_BITS-1:0]         span_mask;
		logic [INDEX_W+COUNT_BITS-1:0] idx_wide;
		count_nx = count_q + 1'b1;
		sel_bit  = 1'b0;
		if (32'(chan_sel_q) < CHANNELS) begin
			sel_bit = sample_s1[chan_sel_q];
		end
		addend       = SUM_W'(sel_bit);
		emit[LEVELS] = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			sum_add   = sum_q[i] + addend;
			span_mask = ~({COUNT_BITS{1'b1}} << (BLOCK_LOG2 * (i + 1)));
			emit[i]   = eot_s1 || ((count_nx & span_mask) == '0);
			if (i == 0) begin
				val = VAL_W'(sum_add);
			end else begin
				val = VAL_W'((sum_add + ROUND_UP) >> BLOCK_LOG2);
			end
			addend    = emit[i] ? SUM_W'(val) : '0;
			sum_nx[i] = emit[i] ? '0 : sum_add;
			// Block index of the closed block is the old count shifted down
			idx_wide  = {{INDEX_W{1'b0}}, count_q} >> (BLOCK_LOG2 * (i + 1));
			push_res[i].level       = LEVEL_W'(i + 1);
			push_res[i].block_index = idx_wide[INDEX_W-1:0];
			push_res[i].block_value = VALUE_W'(val);
			push_res[i].last_result = 1'b0;
		end
		// Levels that emit form a prefix; the last one closes the set
		for (int i = 0; i < LEVELS; i++) begin
			push_res[i].last_result = emit[i] && !emit[i + 1];
		end
	end

	// Sample count and level sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				sum_q[i] <= '0;
			end
		end else if (consume) begin
			count_q <= eot_s1 ? '0 : count_nx;
			for (int i = 0; i < LEVELS; i++) begin
				sum_q[i] <= sum_nx[i];
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/bdmp_serializer.sv
// Holds one result set and hands its results out one per cycle while the receiver takes them.
`default_nettype none

module bdmp_serializer
	import bdmp_pkg::*;
#(
	parameter int LEVELS = DEF_LEVELS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire out_t push_res [LEVELS],
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_res
);

	localparam int PTR_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	logic             set_valid_q;
	out_t             set_q [LEVELS];
	logic [PTR_W-1:0] ptr_q;
	logic             out_valid_q;
	out_t             out_q;
	out_t             cur_res;
	logic             out_load;
	logic             set_done;

	assign cur_res    = set_q[ptr_q];
	assign out_load   = set_valid_q && (!out_valid_q || out_ready);
	assign set_done   = out_load && cur_res.last_result;
	assign push_ready = !set_valid_q || set_done;
	assign out_valid  = out_valid_q;
	assign out_res    = out_q;

	// Set holder and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_valid_q <= 1'b0;
			ptr_q       <= '0;
		end else if (push_valid && push_ready) begin
			set_valid_q <= 1'b1;
			ptr_q       <= '0;
		end else if (set_done) begin
			set_valid_q <= 1'b0;
			ptr_q       <= '0;
		end else if (out_load) begin
			ptr_q <= ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready) begin
			for (int i = 0; i < LEVELS; i++) begin
				set_q[i] <= push_res[i];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= cur_res;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/bit_density_mip_pyramid.sv
// Top level of the bit-density mip pyramid.
//
// Requests (in_valid/in_ready, in_req) carry one logic sample and an
// end-of-trace mark. The bit picked by the channel select register
// (cfg_we/cfg_wdata, no wait) is counted over blocks of 2^BLOCK_LOG2
// samples; each level above sums 2^BLOCK_LOG2 values of the level below
// and gives the rounded-up mean. Each finished block yields one result on
// out_valid/out_ready, lowest level first; end of trace flushes all
// LEVELS levels, then the count and sums clear.
// A request is accepted every cycle while the input stage can empty. Its
// results pass from the input register to the set holder and leave one per
// cycle through the output register while the receiver takes them. A
// later block-closing request waits in the input stage until the holder
// frees. A stalled receiver fills the output register and the set holder;
// requests that close no block still pass, and in_ready drops once the
// input stage holds a request whose results cannot be taken.
// Reset clears the select register, the sample count and all level sums.
`default_nettype none

module bit_density_mip_pyramid
	import bdmp_pkg::*;
#(
	parameter int LEVELS     = DEF_LEVELS,
	parameter int BLOCK_LOG2 = DEF_BLOCK_LOG2,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [SEL_W-1:0] cfg_wdata,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire in_t              in_req,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output out_t                  out_res
);

	logic push_valid;
	logic push_ready;
	out_t push_res [LEVELS];

	// Counting and level update
	bdmp_engine #(
		.LEVELS     (LEVELS),
		.BLOCK_LOG2 (BLOCK_LOG2),
		.COUNT_BITS (COUNT_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_req     (in_req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_res   (push_res)
	);

	// One result per cycle to the receiver while it takes them
	bdmp_serializer #(
		.LEVELS (LEVELS)
	) u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_res   (push_res),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_res    (out_res)
	);

endmodule

`default_nettype wire
